// ----- rtl/dbmr_pkg.sv -----
// Shared types and constants for the dedup bag with middle removal.
// No dependencies; dbmr_ctrl and the top level use this package.
`timescale 1ns / 1ps

package dbmr_pkg;

   localparam int CAPACITY_DEF    = 16;
   localparam int VALUE_WIDTH_DEF = 32;

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_REMOVE = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_REMOVED   = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef struct packed {
      logic               action;
      logic signed [31:0] item_value;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] removed_value;
      logic [4:0]         entry_count;
      logic               is_empty;
      logic               is_full;
   } rsp_type;

endpackage

// ----- rtl/dbmr_mem.sv -----
// Entry store: one write port, one read port, registered read data.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module dbmr_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/dbmr_ctrl.sv -----
// Sequencer: duplicate scan and middle-removal shift over the entry store.
// Depends on dbmr_pkg; drives dbmr_mem ports through the top level.
`timescale 1ns / 1ps

module dbmr_ctrl #(
   parameter int CAPACITY    = dbmr_pkg::CAPACITY_DEF,
   parameter int VALUE_WIDTH = dbmr_pkg::VALUE_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  dbmr_pkg::req_type           req_data,
   output logic                        done_valid,
   input  logic                        done_take,
   output dbmr_pkg::rsp_type           done_data,
   output logic                        mem_we,
   output logic [$clog2(CAPACITY)-1:0] mem_waddr,
   output logic [VALUE_WIDTH-1:0]      mem_wdata,
   output logic [$clog2(CAPACITY)-1:0] mem_raddr,
   input  logic [VALUE_WIDTH-1:0]      mem_rdata
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_SHIFT = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic                   pend_ff, pend_in;
   logic                   first_ff, first_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [VALUE_WIDTH-1:0] removed_ff, removed_in;
   dbmr_pkg::status_type   status_ff, status_in;

   logic                   accept;
   logic                   issue;
   logic [CW-1:0]          mid_idx;
   logic [63:0]            in_ext;
   logic [63:0]            rem_ext;
   logic [CW-1:0]          count_rsp;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign issue     = (rd_ptr_ff < count_ff);
   assign mid_idx   = (count_ff - CW'(1)) >> 1;
   assign in_ext    = {32'd0, req_data.item_value};
   assign mem_raddr = rd_ptr_ff[IW-1:0];

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      rd_ptr_in  = rd_ptr_ff;
      wr_ptr_in  = wr_ptr_ff;
      pend_in    = 1'b0;
      first_in   = first_ff;
      val_in     = val_ff;
      removed_in = removed_ff;
      status_in  = status_ff;
      mem_we     = 1'b0;
      mem_waddr  = wr_ptr_ff[IW-1:0];
      mem_wdata  = mem_rdata;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               val_in     = in_ext[VALUE_WIDTH-1:0];
               removed_in = '0;
               pend_in    = 1'b0;
               first_in   = 1'b1;
               if (req_data.action == dbmr_pkg::ACT_INSERT) begin
                  rd_ptr_in = '0;
                  state_in  = S_SCAN;
               end else if (count_ff == '0) begin
                  status_in = dbmr_pkg::ST_EMPTY;
                  state_in  = S_DONE;
               end else begin
                  rd_ptr_in = mid_idx;
                  wr_ptr_in = mid_idx;
                  state_in  = S_SHIFT;
               end
            end
         end
         S_SCAN: begin
            pend_in   = issue;
            rd_ptr_in = issue ? rd_ptr_ff + CW'(1) : rd_ptr_ff;
            if (pend_ff && (mem_rdata == val_ff)) begin
               status_in = dbmr_pkg::ST_DUPLICATE;
               state_in  = S_DONE;
            end else if (!pend_ff && !issue) begin
               if (count_ff == CW'(CAPACITY)) begin
                  status_in = dbmr_pkg::ST_FULL;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = count_ff[IW-1:0];
                  mem_wdata = val_ff;
                  count_in  = count_ff + CW'(1);
                  status_in = dbmr_pkg::ST_INSERTED;
               end
               state_in = S_DONE;
            end
         end
         S_SHIFT: begin
            pend_in   = issue;
            rd_ptr_in = issue ? rd_ptr_ff + CW'(1) : rd_ptr_ff;
            if (pend_ff) begin
               if (first_ff) begin
                  removed_in = mem_rdata;
                  first_in   = 1'b0;
               end else begin
                  mem_we    = 1'b1;
                  wr_ptr_in = wr_ptr_ff + CW'(1);
               end
            end else if (!issue) begin
               count_in  = count_ff - CW'(1);
               status_in = dbmr_pkg::ST_REMOVED;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (done_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff  <= rd_ptr_in;
      wr_ptr_ff  <= wr_ptr_in;
      first_ff   <= first_in;
      val_ff     <= val_in;
      removed_ff <= removed_in;
      status_ff  <= status_in;
   end

   assign rem_ext    = 64'(removed_ff);
   assign count_rsp  = count_ff;
   assign done_valid = (state_ff == S_DONE);

   always_comb begin
      done_data               = '0;
      done_data.status        = status_ff;
      done_data.removed_value = rem_ext[31:0];
      done_data.entry_count   = 5'(count_rsp);
      done_data.is_empty      = (count_ff == '0);
      done_data.is_full       = (count_ff == CW'(CAPACITY));
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_SCAN || state_ff == S_SHIFT))
      else $error("store written outside scan or shift");

   a_shift_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && pend_ff && !first_ff) |-> (wr_ptr_ff < rd_ptr_ff))
      else $error("shift write does not trail read");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("accepted transaction did not start");

   a_done_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> $stable(count_ff))
      else $error("count changed after result was formed");

endmodule

// ----- rtl/dedup_bag_middle_remove.sv -----
// Top level of the dedup bag with middle removal.
// Depends on dbmr_pkg, dbmr_mem and dbmr_ctrl.
// Usage:
//   req_valid/req_ready/req_data carry one transaction: action insert or
//   remove, and item_value for an insert. rsp_valid/rsp_ready/rsp_data
//   return exactly one result per transaction, in order.
//   Entries live in a single-port-write, registered-read memory; every
//   access to the store goes through it, one entry per cycle.
//   Insert: the duplicate scan reads each stored entry once and stops
//   early when a duplicate is found; otherwise the new entry is written
//   at the end unless the store is full. Remove: the middle entry is read
//   and every later entry is moved down one place.
//   A remove on an empty store answers with the empty status and no shift.
//   One transaction is worked on at a time; req_ready is high whenever the
//   sequencer is idle, even while a previous result waits in the output
//   register. If rsp_ready is low, the finished result holds in the
//   sequencer until the output register frees.
//   Reset clears the count and the handshake state; stored entries are
//   left as they are and never read before being written.
`timescale 1ns / 1ps

module dedup_bag_middle_remove #(
   parameter int CAPACITY    = dbmr_pkg::CAPACITY_DEF,
   parameter int VALUE_WIDTH = dbmr_pkg::VALUE_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dbmr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dbmr_pkg::rsp_type rsp_data
);

   localparam int IW = $clog2(CAPACITY);

   logic                   done_valid;
   logic                   done_take;
   dbmr_pkg::rsp_type      done_data;
   logic                   mem_we;
   logic [IW-1:0]          mem_waddr;
   logic [VALUE_WIDTH-1:0] mem_wdata;
   logic [IW-1:0]          mem_raddr;
   logic [VALUE_WIDTH-1:0] mem_rdata;

   logic                   rsp_valid_ff, rsp_valid_in;
   dbmr_pkg::rsp_type      rsp_data_ff;

   dbmr_ctrl #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .done_valid (done_valid),
      .done_take  (done_take),
      .done_data  (done_data),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   dbmr_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (VALUE_WIDTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign done_take    = done_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = done_take || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done_take) begin
         rsp_data_ff <= done_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
